/* rtl/rdrf_pkg.sv */
// ---------------------------------------------------------------------------
// rdrf_pkg
// shared sizes, codes and record types of the request dedup rate filter
// ---------------------------------------------------------------------------
`default_nettype none

package rdrf_pkg;

  localparam int NUM_DEVICES        = 16;
  localparam int CODES_PER_DEVICE   = 16;
  localparam int CHECKSUMS_PER_CODE = 16;

  localparam int N_SLOTS = NUM_DEVICES * CODES_PER_DEVICE;
  localparam int N_SUMS  = N_SLOTS * CHECKSUMS_PER_CODE;

  localparam int D_W    = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int C_W    = (CODES_PER_DEVICE > 1) ? $clog2(CODES_PER_DEVICE) : 1;
  localparam int K_W    = (CHECKSUMS_PER_CODE > 1) ? $clog2(CHECKSUMS_PER_CODE) : 1;
  localparam int CNT_W  = $clog2(CHECKSUMS_PER_CODE + 1);
  localparam int SLOT_W = (N_SLOTS > 1) ? $clog2(N_SLOTS) : 1;
  localparam int CK_W   = (N_SUMS > 1) ? $clog2(N_SUMS) : 1;

  localparam logic [31:0] LIMIT_OFF = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_CHECK   = 2'd0,
    CMD_CLR_DEV = 2'd1,
    CMD_CLR_ALL = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_UNLIMITED = 3'd0,
    ST_LOGGED    = 3'd1,
    ST_OVER      = 3'd2,
    ST_DUP       = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0] ckn;
    logic [31:0]      count;
    logic [31:0]      size;
    logic [31:0]      code;
  } slot_t;

  typedef struct packed {
    status_t status;
    logic    allow;
  } res_t;

endpackage

`default_nettype wire

/* rtl/request_dedup_rate_filter_core.sv */
// ---------------------------------------------------------------------------
// request_dedup_rate_filter_core
// per-device, per-code hit limiting and duplicate checksum suppression
// ---------------------------------------------------------------------------
//  channel | dir | ports                           | word
//  in      | in  | in_tvalid/in_tready/in_t*       | request or clear command
//  out     | out | out_tvalid/out_tready/out_tdata | allow and status
//  cfg     | in  | cfg_valid/cfg_ready/cfg_data    | hit limit
//
//  a check scans the device ids, then reads the code slots of the matching device
//  and compares the stored checksums, each slot and checksum read going through
//  a registered ram read; clear device scans every device entry
//  clear all and unlimited checks go straight to the response
//  reset and clear all empty the tables at once through per-slot valid bits
//  a waiting result sits in the output register; the next word is taken meanwhile
// ---------------------------------------------------------------------------
`default_nettype none

module request_dedup_rate_filter_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [159:0] in_tdata,   // device_id, request_code, request_size, content_checksum
  input  wire logic [1:0]   in_tuser,   // cmd
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [7:0]        out_tdata,  // allow, status, zero pad
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [31:0]  cfg_data
);
  import rdrf_pkg::*;

  logic [31:0]       limit_r;
  logic              out_valid_r;
  res_t              out_r;
  logic              res_valid, res_ready;
  res_t              res;
  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr, slot_raddr;
  slot_t             slot_wdata, slot_rdata;
  logic              ck_we;
  logic [CK_W-1:0]   ck_waddr, ck_raddr;
  logic [31:0]       ck_wdata, ck_rdata;

  assign cfg_ready  = 1'b1;
  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_OFF;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      if (res_ready) begin
        out_valid_r <= res_valid;
      end
    end
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  rdrf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_dev     (in_tdata[63:0]),
    .in_code    (in_tdata[95:64]),
    .in_size    (in_tdata[127:96]),
    .in_sum     (in_tdata[159:128]),
    .limit      (limit_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .slot_we    (slot_we),
    .slot_waddr (slot_waddr),
    .slot_wdata (slot_wdata),
    .slot_raddr (slot_raddr),
    .slot_rdata (slot_rdata),
    .ck_we      (ck_we),
    .ck_waddr   (ck_waddr),
    .ck_wdata   (ck_wdata),
    .ck_raddr   (ck_raddr),
    .ck_rdata   (ck_rdata)
  );

  rdrf_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (N_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  rdrf_ram #(
    .WIDTH (32),
    .DEPTH (N_SUMS)
  ) u_ck_ram (
    .clk   (clk),
    .we    (ck_we),
    .waddr (ck_waddr),
    .wdata (ck_wdata),
    .raddr (ck_raddr),
    .rdata (ck_rdata)
  );

endmodule

`default_nettype wire

/* rtl/rdrf_ram.sv */
// ---------------------------------------------------------------------------
// rdrf_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module rdrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/rdrf_ctrl.sv */
// ---------------------------------------------------------------------------
// rdrf_ctrl
// sequencer: device scan, slot read-modify-write and checksum list search
// ---------------------------------------------------------------------------
`default_nettype none

module rdrf_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_cmd,
  input  wire logic [63:0]           in_dev,
  input  wire logic [31:0]           in_code,
  input  wire logic [31:0]           in_size,
  input  wire logic [31:0]           in_sum,
  input  wire logic [31:0]           limit,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output rdrf_pkg::res_t             res,
  output logic                       slot_we,
  output logic [rdrf_pkg::SLOT_W-1:0] slot_waddr,
  output rdrf_pkg::slot_t            slot_wdata,
  output logic [rdrf_pkg::SLOT_W-1:0] slot_raddr,
  input  wire rdrf_pkg::slot_t       slot_rdata,
  output logic                       ck_we,
  output logic [rdrf_pkg::CK_W-1:0]  ck_waddr,
  output logic [31:0]                ck_wdata,
  output logic [rdrf_pkg::CK_W-1:0]  ck_raddr,
  input  wire logic [31:0]           ck_rdata
);
  import rdrf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEV, S_SRD, S_SEV, S_KRD, S_KEV, S_WR, S_LOAD, S_FREE, S_CLR, S_RESP
  } state_t;

  state_t           state_r, state_nxt;
  logic [D_W-1:0]   d_r, d_nxt;
  logic [C_W-1:0]   c_r, c_nxt;
  logic [C_W-1:0]   fc_r, fc_nxt;
  logic             ff_r, ff_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [31:0]      cnt_r, cnt_nxt;
  logic [63:0]      ids_r [NUM_DEVICES];
  logic [63:0]      ids_nxt [NUM_DEVICES];
  logic [N_SLOTS-1:0] vld_r, vld_nxt;
  logic             rvld_r, rvld_nxt;
  logic [63:0]      dev_r, dev_nxt;
  logic [31:0]      code_r, code_nxt;
  logic [31:0]      size_r, size_nxt;
  logic [31:0]      sum_r, sum_nxt;
  status_t          st_r, st_nxt;

  slot_t            rd;
  logic [SLOT_W-1:0] s_cur;
  logic [SLOT_W-1:0] s_clr;
  logic [CNT_W-1:0] n_eff;
  logic             d_last, c_last;

  assign s_cur  = SLOT_W'(d_r * CODES_PER_DEVICE + c_r);
  assign rd     = rvld_r ? slot_rdata : '0;
  assign n_eff  = (rd.ckn > CNT_W'(CHECKSUMS_PER_CODE)) ? CNT_W'(CHECKSUMS_PER_CODE) : rd.ckn;
  assign d_last = (d_r == D_W'(NUM_DEVICES - 1));
  assign c_last = (c_r == C_W'(CODES_PER_DEVICE - 1));

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res.status = st_r;
  assign res.allow  = (st_r == ST_UNLIMITED) || (st_r == ST_LOGGED);

  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    c_nxt     = c_r;
    fc_nxt    = fc_r;
    ff_nxt    = ff_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    cnt_nxt   = cnt_r;
    ids_nxt   = ids_r;
    vld_nxt   = vld_r;
    rvld_nxt  = rvld_r;
    dev_nxt   = dev_r;
    code_nxt  = code_r;
    size_nxt  = size_r;
    sum_nxt   = sum_r;
    st_nxt    = st_r;
    s_clr     = '0;

    slot_we    = 1'b0;
    slot_waddr = s_cur;
    slot_wdata = '0;
    slot_raddr = s_cur;
    ck_we      = 1'b0;
    ck_waddr   = CK_W'(s_cur * CHECKSUMS_PER_CODE);
    ck_wdata   = sum_r;
    ck_raddr   = CK_W'(s_cur * CHECKSUMS_PER_CODE + k_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dev_nxt  = in_dev;
          code_nxt = in_code;
          size_nxt = in_size;
          sum_nxt  = in_sum;
          d_nxt    = '0;
          st_nxt   = ST_CLEARED;
          case (in_cmd)
            CMD_CHECK: begin
              if (limit == LIMIT_OFF) begin
                st_nxt    = ST_UNLIMITED;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_DEV;
              end
            end
            CMD_CLR_DEV: state_nxt = S_CLR;
            CMD_CLR_ALL: begin
              vld_nxt = '0;
              for (int i = 0; i < NUM_DEVICES; i++) begin
                ids_nxt[i] = '0;
              end
              state_nxt = S_RESP;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_DEV: begin
        if (ids_r[d_r] == dev_r) begin
          c_nxt     = '0;
          ff_nxt    = 1'b0;
          state_nxt = S_SRD;
        end else if (d_last) begin
          d_nxt     = '0;
          state_nxt = S_FREE;
        end else begin
          d_nxt = d_r + 1'b1;
        end
      end
      S_SRD: begin
        rvld_nxt  = vld_r[s_cur];
        state_nxt = S_SEV;
      end
      S_SEV: begin
        if (rd.code == code_r && rd.size == size_r) begin
          cnt_nxt = rd.count;
          n_nxt   = n_eff;
          k_nxt   = '0;
          if (rd.count >= limit) begin
            st_nxt    = ST_OVER;
            state_nxt = S_RESP;
          end else if (n_eff == '0) begin
            state_nxt = S_WR;
          end else begin
            state_nxt = S_KRD;
          end
        end else begin
          if (!ff_r && rd.code == '0) begin
            ff_nxt = 1'b1;
            fc_nxt = c_r;
          end
          if (c_last) begin
            if (ff_r) begin
              c_nxt     = fc_r;
              state_nxt = S_LOAD;
            end else if (rd.code == '0) begin
              state_nxt = S_LOAD;
            end else if (d_last) begin
              d_nxt     = '0;
              state_nxt = S_FREE;
            end else begin
              d_nxt     = d_r + 1'b1;
              state_nxt = S_DEV;
            end
          end else begin
            c_nxt     = c_r + 1'b1;
            state_nxt = S_SRD;
          end
        end
      end
      S_KRD: state_nxt = S_KEV;
      S_KEV: begin
        if (ck_rdata == sum_r) begin
          st_nxt    = ST_DUP;
          state_nxt = S_RESP;
        end else if ((CNT_W'(k_r) + CNT_W'(1)) == n_r) begin
          state_nxt = S_WR;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_KRD;
        end
      end
      S_WR: begin
        slot_we          = 1'b1;
        slot_wdata.code  = code_r;
        slot_wdata.size  = size_r;
        slot_wdata.count = cnt_r + 32'd1;
        slot_wdata.ckn   = n_r;
        vld_nxt[s_cur]   = 1'b1;
        if (n_r < CNT_W'(CHECKSUMS_PER_CODE)) begin
          slot_wdata.ckn = n_r + 1'b1;
          ck_we          = 1'b1;
          ck_waddr       = CK_W'(s_cur * CHECKSUMS_PER_CODE + n_r);
        end
        st_nxt    = ST_LOGGED;
        state_nxt = S_RESP;
      end
      S_LOAD: begin
        slot_we          = 1'b1;
        slot_wdata.code  = code_r;
        slot_wdata.size  = size_r;
        slot_wdata.count = 32'd1;
        slot_wdata.ckn   = CNT_W'(1);
        vld_nxt[s_cur]   = 1'b1;
        ck_we            = 1'b1;
        st_nxt           = ST_LOGGED;
        state_nxt        = S_RESP;
      end
      S_FREE: begin
        if (ids_r[d_r] == '0) begin
          ids_nxt[d_r] = dev_r;
          c_nxt        = '0;
          state_nxt    = S_LOAD;
        end else if (d_last) begin
          st_nxt    = ST_FULL;
          state_nxt = S_RESP;
        end else begin
          d_nxt = d_r + 1'b1;
        end
      end
      S_CLR: begin
        if (ids_r[d_r] == dev_r) begin
          for (int j = 0; j < CODES_PER_DEVICE; j++) begin
            s_clr          = SLOT_W'(d_r * CODES_PER_DEVICE + j);
            vld_nxt[s_clr] = 1'b0;
          end
        end
        if (d_last) begin
          state_nxt = S_RESP;
        end else begin
          d_nxt = d_r + 1'b1;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
      for (int i = 0; i < NUM_DEVICES; i++) begin
        ids_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      ids_r   <= ids_nxt;
    end
    d_r    <= d_nxt;
    c_r    <= c_nxt;
    fc_r   <= fc_nxt;
    ff_r   <= ff_nxt;
    k_r    <= k_nxt;
    n_r    <= n_nxt;
    cnt_r  <= cnt_nxt;
    rvld_r <= rvld_nxt;
    dev_r  <= dev_nxt;
    code_r <= code_nxt;
    size_r <= size_nxt;
    sum_r  <= sum_nxt;
    st_r   <= st_nxt;
  end

endmodule

`default_nettype wire

/* tb/sv/tb_request_dedup_rate_filter_core.sv */
// ---------------------------------------------------------------------------
// tb_request_dedup_rate_filter_core
// drives check and clear words into the filter under random idling on both
// sides, predicts allow and status from a behavioural copy of the device and
// code slot tables, and compares every result word in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_request_dedup_rate_filter_core;
  import rdrf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 700;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;

  request_dedup_rate_filter_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] dev;
    logic [31:0] code;
    logic [31:0] size;
    logic [31:0] sum;
  } req_t;

  typedef struct packed {
    logic        allow;
    logic [2:0]  status;
  } verdict_t;

  // predictor state
  logic [31:0] limit_q;
  logic [63:0] dev_tab [NUM_DEVICES];
  logic [31:0] code_tab [N_SLOTS];
  logic [31:0] size_tab [N_SLOTS];
  logic [31:0] hits_tab [N_SLOTS];
  int          nsum_tab [N_SLOTS];
  logic [31:0] sum_tab [N_SLOTS][CHECKSUMS_PER_CODE];

  verdict_t expected_verdicts[$];
  int       mismatches = 0;
  int       words_in = 0, words_out = 0, checks_sent = 0;
  int       idle_cycles = 0;
  int       status_seen [8];
  bit       stim_done = 1'b0;

  function automatic void wipe_tables();
    for (int d = 0; d < NUM_DEVICES; d++) dev_tab[d] = '0;
    for (int s = 0; s < N_SLOTS; s++) begin
      code_tab[s] = '0; size_tab[s] = '0; hits_tab[s] = '0; nsum_tab[s] = 0;
    end
  endfunction

  function automatic void take_slot(int s, req_t r);
    code_tab[s] = r.code; size_tab[s] = r.size; hits_tab[s] = 32'd1;
    nsum_tab[s] = 1; sum_tab[s][0] = r.sum;
  endfunction

  function automatic status_t judge_request(req_t r);
    int s, n;
    if (limit_q == LIMIT_OFF) return ST_UNLIMITED;
    for (int d = 0; d < NUM_DEVICES; d++) begin
      if (dev_tab[d] != r.dev) continue;
      for (int c = 0; c < CODES_PER_DEVICE; c++) begin
        s = d * CODES_PER_DEVICE + c;
        if (code_tab[s] != r.code || size_tab[s] != r.size) continue;
        if (hits_tab[s] >= limit_q) return ST_OVER;
        n = nsum_tab[s];
        for (int k = 0; k < n; k++)
          if (sum_tab[s][k] == r.sum) return ST_DUP;
        hits_tab[s] = hits_tab[s] + 32'd1;
        if (n < CHECKSUMS_PER_CODE) begin
          sum_tab[s][n] = r.sum;
          nsum_tab[s] = n + 1;
        end
        return ST_LOGGED;
      end
      for (int c = 0; c < CODES_PER_DEVICE; c++) begin
        s = d * CODES_PER_DEVICE + c;
        if (code_tab[s] == '0) begin
          take_slot(s, r);
          return ST_LOGGED;
        end
      end
    end
    for (int d = 0; d < NUM_DEVICES; d++) begin
      if (dev_tab[d] == '0) begin
        dev_tab[d] = r.dev;
        take_slot(d * CODES_PER_DEVICE, r);
        return ST_LOGGED;
      end
    end
    return ST_FULL;
  endfunction

  function automatic verdict_t predict_verdict(req_t r);
    verdict_t v;
    status_t st;
    v.allow = 1'b0;
    v.status = ST_CLEARED;
    if (r.cmd == CMD_CHECK) begin
      st = judge_request(r);
      v.status = st;
      v.allow = (st == ST_UNLIMITED || st == ST_LOGGED);
    end else if (r.cmd == CMD_CLR_DEV) begin
      for (int d = 0; d < NUM_DEVICES; d++)
        if (dev_tab[d] == r.dev)
          for (int c = 0; c < CODES_PER_DEVICE; c++) begin
            code_tab[d*CODES_PER_DEVICE+c] = '0; size_tab[d*CODES_PER_DEVICE+c] = '0;
            hits_tab[d*CODES_PER_DEVICE+c] = '0; nsum_tab[d*CODES_PER_DEVICE+c] = 0;
          end
    end else if (r.cmd == CMD_CLR_ALL) begin
      wipe_tables();
    end
    return v;
  endfunction

  function automatic int short_or_long_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // result side: sample at rising edge, stall at falling edge
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.allow = out_tdata[0];
      got.status = out_tdata[3:1];
      words_out++;
      status_seen[got.status]++;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        want = expected_verdicts.pop_front();
        if (got.allow !== want.allow || got.status !== want.status
            || out_tdata[7:4] !== 4'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected allow %b status %0d, got allow %b status %0d pad %h",
                     words_out, want.allow, want.status, got.allow, got.status, out_tdata[7:4]);
        end
      end
    end
  end

  int stall_left = 0;
  bit steady_phase = 1'b0;
  always @(negedge clk) begin
    if (!rst_n || steady_phase) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      stall_left = short_or_long_gap();
      out_tready <= (stall_left == 0);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("** request_dedup_rate_filter_core: FAILED **");
      $finish;
    end
  end

  // valid stays up after a word until the next gap or the next word
  task automatic send_word(req_t r, bit typed, verdict_t typed_v);
    verdict_t v;
    int gap;
    gap = short_or_long_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {r.sum, r.size, r.code, r.dev};
    in_tuser <= r.cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    v = predict_verdict(r);
    if (typed && v != typed_v) begin
      mismatches++;
      if (mismatches <= 10) $display("table row %0d disagrees with predictor", words_in);
    end
    expected_verdicts.push_back(v);
    words_in++;
    if (r.cmd == CMD_CHECK) checks_sent++;
    @(negedge clk);
  endtask

  task automatic settle_and_configure(logic [31:0] lim);
    in_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_data <= lim;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    limit_q = lim;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t mk(logic [1:0] c, logic [63:0] d, logic [31:0] co,
                              logic [31:0] sz, logic [31:0] su);
    req_t r;
    r.cmd = c; r.dev = d; r.code = co; r.size = sz; r.sum = su;
    return r;
  endfunction

  // random request drawn from a small pool so slots fill, repeat and overflow
  function automatic req_t random_request(int pool);
    req_t r;
    int p;
    p = $urandom_range(0, 99);
    r.cmd = (p < 88) ? CMD_CHECK : (p < 95) ? CMD_CLR_DEV : (p < 98) ? CMD_CLR_ALL : 2'd3;
    r.dev = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} :
            64'(($urandom_range(0, pool) * 64'h9E37_79B9_7F4A_7C15));
    r.code = ($urandom_range(0, 15) == 0) ? $urandom : 32'($urandom_range(0, 19));
    r.size = ($urandom_range(0, 15) == 0) ? $urandom : 32'($urandom_range(0, 2) << 30);
    r.sum = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 24));
    return r;
  endfunction

  typedef struct {
    req_t     r;
    bit       typed;
    verdict_t v;
  } row_t;

  row_t rows[$];

  initial begin
    verdict_t vu, vl, vc, vd, vo;
    logic [31:0] limits [6];
    limit_q = LIMIT_OFF;
    wipe_tables();
    vu = '{1'b1, ST_UNLIMITED}; vl = '{1'b1, ST_LOGGED}; vc = '{1'b0, ST_CLEARED};
    vd = '{1'b0, ST_DUP};       vo = '{1'b0, ST_OVER};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // limit at reset value: every check unlimited
    rows.push_back('{mk(CMD_CHECK, '1, '1, '1, '1), 1, vu});
    rows.push_back('{mk(CMD_CHECK, '0, '0, '0, '0), 1, vu});
    rows.push_back('{mk(2'd3, 64'h5, 32'h1, 32'h2, 32'h3), 1, vc});
    foreach (rows[i]) send_word(rows[i].r, rows[i].typed, rows[i].v);
    rows.delete();

    settle_and_configure(32'd2);
    rows.push_back('{mk(CMD_CHECK, '1, '1, '1, '1), 1, vl});
    rows.push_back('{mk(CMD_CHECK, '1, '1, '1, '1), 1, vd});
    rows.push_back('{mk(CMD_CHECK, '1, '1, '1, 32'h0), 1, vl});
    rows.push_back('{mk(CMD_CHECK, '1, '1, '1, 32'h7), 1, vo});
    // device id zero and code zero
    rows.push_back('{mk(CMD_CHECK, '0, '0, 32'h8000_0000, 32'h1), 1, vl});
    rows.push_back('{mk(CMD_CHECK, '0, '0, 32'h8000_0000, 32'h2), 0, vl});
    rows.push_back('{mk(CMD_CHECK, 64'hA5, 32'h10, '0, 32'h1), 0, vl});
    // clear device then recheck
    rows.push_back('{mk(CMD_CLR_DEV, '1, '0, '0, '0), 1, vc});
    rows.push_back('{mk(CMD_CHECK, '1, '1, '1, '1), 1, vl});
    rows.push_back('{mk(2'd3, '1, '1, '1, '1), 1, vc});
    rows.push_back('{mk(CMD_CLR_ALL, '0, '0, '0, '0), 1, vc});
    rows.push_back('{mk(CMD_CHECK, '1, '1, '1, '1), 1, vl});
    foreach (rows[i]) send_word(rows[i].r, rows[i].typed, rows[i].v);
    rows.delete();

    // limit zero: new slots logged, known slots refused
    settle_and_configure(32'd0);
    send_word(mk(CMD_CHECK, '1, '1, '1, 32'h9), 1, vo);
    send_word(mk(CMD_CHECK, 64'h77, 32'h3, 32'h4, 32'h5), 1, vl);
    // big limit: fill a device past its code slots and the table past full
    settle_and_configure(32'hFFFF_FFFE);
    for (int i = 0; i < 20; i++)
      send_word(mk(CMD_CHECK, 64'h1234, 32'(i + 1), 32'h0, 32'(i)), 0, vl);
    for (int i = 0; i < 18; i++)
      send_word(mk(CMD_CHECK, 64'(i + 100), 32'h1, 32'h1, 32'h1), 0, vl);
    // checksum list overflow
    send_word(mk(CMD_CLR_ALL, '0, '0, '0, '0), 1, vc);
    for (int i = 0; i < 19; i++)
      send_word(mk(CMD_CHECK, 64'h42, 32'h9, 32'h9, 32'(i)), 0, vl);

    limits = '{32'd1, 32'd3, 32'd6, 32'd20, 32'h8000_0000, LIMIT_OFF};
    for (int ph = 0; ph < 6; ph++) begin
      settle_and_configure(limits[ph]);
      steady_phase = (ph == 2);
      for (int i = 0; i < 72; i++)
        send_word(random_request(ph == 4 ? 24 : 6), 0, vl);
    end
    steady_phase = 1'b0;
    stim_done = 1'b1;
    in_tvalid <= 1'b0;

    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d words sent (%0d checks), %0d results checked over 9 limit settings",
             words_in, checks_sent, words_out);
    $display("status counts: unlim %0d logged %0d over %0d dup %0d full %0d cleared %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatches == 0 && expected_verdicts.size() == 0)
      $display("** request_dedup_rate_filter_core: PASSED **");
    else
      $display("** request_dedup_rate_filter_core: FAILED **");
    $finish;
  end

endmodule
